FILE: rtl/core/wts_pkg.sv
// Shared constants, register indexes and the quarter-wave sine helper
// for the woven thread pixel shader. No dependencies.
`timescale 1ns / 1ps

package wts_pkg;

  localparam int DEF_COORD_BITS = 12;
  localparam int DEF_SINE_DEPTH = 256;

  localparam int CFG_W  = 7;
  localparam int CIDX_W = 2;

  localparam logic [CIDX_W-1:0] REG_THREAD_WIDTH  = 2'd0;
  localparam logic [CIDX_W-1:0] REG_GAP_WIDTH     = 2'd1;
  localparam logic [CIDX_W-1:0] REG_DEPTH_PERCENT = 2'd2;

  localparam logic [CFG_W-1:0] RST_THREAD_WIDTH  = 7'd8;
  localparam logic [CFG_W-1:0] RST_GAP_WIDTH     = 7'd4;
  localparam logic [CFG_W-1:0] RST_DEPTH_PERCENT = 7'd0;
  localparam logic [CFG_W-1:0] MIN_WIDTH         = 7'd2;
  localparam logic [CFG_W-1:0] MAX_DEPTH         = 7'd100;

  localparam int SHADE_W = 17;
  localparam logic [SHADE_W-1:0] SHADE_BASE  = 17'd36045;
  localparam logic [14:0]        SHADE_SWING = 15'd29491;

  localparam longint Q30_ONE     = 64'sd1 << 30;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;

  // Taylor series of the sine in Q30, rounded to nearest Q16 and capped at one.
  // Each term divides the previous one by (2n)(2n+1), written out per term.
  function automatic int unsigned wts_quarter_sine(input longint x);
    longint x2;
    longint term;
    longint sum;
    x2   = (x * x) / Q30_ONE;
    term = x;
    sum  = x;
    term = -((term * x2) / Q30_ONE) / 64'sd6;
    sum  = sum + term;
    term = -((term * x2) / Q30_ONE) / 64'sd20;
    sum  = sum + term;
    term = -((term * x2) / Q30_ONE) / 64'sd42;
    sum  = sum + term;
    term = -((term * x2) / Q30_ONE) / 64'sd72;
    sum  = sum + term;
    term = -((term * x2) / Q30_ONE) / 64'sd110;
    sum  = sum + term;
    term = -((term * x2) / Q30_ONE) / 64'sd156;
    sum  = sum + term;
    term = -((term * x2) / Q30_ONE) / 64'sd210;
    sum  = sum + term;
    if (sum < 0) sum = 0;
    sum = (sum + 64'sd8192) / 64'sd16384;
    if (sum > 64'sd65536) sum = 64'sd65536;
    return int'(sum);
  endfunction

endpackage

FILE: rtl/core/wts_div.sv
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// Depends on nothing; the divisor must stay steady while beats are in flight.
`timescale 1ns / 1ps

module wts_div #(
  parameter int NUM_W = 12,
  parameter int DEN_W = 8,
  parameter int SB_W  = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [NUM_W-1:0] in_num,
  input  logic [DEN_W-1:0] in_den,
  input  logic [SB_W-1:0]  in_sb,
  output logic             out_valid,
  output logic [NUM_W-1:0] out_quo,
  output logic [DEN_W-1:0] out_rem,
  output logic [SB_W-1:0]  out_sb
);

  logic             v_r   [0:NUM_W-1];
  logic [DEN_W-1:0] rem_r [0:NUM_W-1];
  logic [NUM_W-1:0] num_r [0:NUM_W-1];
  logic [NUM_W-1:0] quo_r [0:NUM_W-1];
  logic [SB_W-1:0]  sb_r  [0:NUM_W-1];

  for (genvar i = 0; i < NUM_W; i++) begin : g_stage
    logic             v_in;
    logic [DEN_W-1:0] rem_in;
    logic [NUM_W-1:0] num_in;
    logic [NUM_W-1:0] quo_in;
    logic [SB_W-1:0]  sb_in;
    logic [DEN_W:0]   trial;
    logic             fits;
    logic [DEN_W-1:0] rem_nxt;

    if (i == 0) begin : g_first
      assign v_in   = in_valid;
      assign rem_in = '0;
      assign num_in = in_num;
      assign quo_in = '0;
      assign sb_in  = in_sb;
    end else begin : g_next
      assign v_in   = v_r[i-1];
      assign rem_in = rem_r[i-1];
      assign num_in = num_r[i-1];
      assign quo_in = quo_r[i-1];
      assign sb_in  = sb_r[i-1];
    end

    assign trial   = {rem_in, num_in[NUM_W-1]};
    assign fits    = trial >= {1'b0, in_den};
    assign rem_nxt = fits ? DEN_W'(trial - {1'b0, in_den}) : trial[DEN_W-1:0];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else begin
        v_r[i] <= v_in;
      end
      rem_r[i] <= rem_nxt;
      num_r[i] <= num_in << 1;
      quo_r[i] <= {quo_in[NUM_W-2:0], fits};
      sb_r[i]  <= sb_in;
    end
  end

  assign out_valid = v_r[NUM_W-1];
  assign out_quo   = quo_r[NUM_W-1];
  assign out_rem   = rem_r[NUM_W-1];
  assign out_sb    = sb_r[NUM_W-1];

endmodule

FILE: rtl/core/wts_shade.sv
// Shade pipeline: sine table lookup, shade scaling and crossing darkening.
// Depends on wts_pkg for the sine helper and shade constants.
`timescale 1ns / 1ps

module wts_shade
  import wts_pkg::*;
#(
  parameter int SINE_DEPTH = DEF_SINE_DEPTH,
  parameter int Q_W        = 18,
  parameter int SB_W       = 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [CFG_W-1:0]   depth_pct,
  input  logic               in_valid,
  input  logic [Q_W-1:0]     in_q,
  input  logic               in_cross,
  input  logic [SB_W-1:0]    in_sb,
  output logic               out_valid,
  output logic [SHADE_W-1:0] out_shade,
  output logic [SB_W-1:0]    out_sb
);

  localparam int IDX_W = $clog2(SINE_DEPTH + 1);
  localparam logic [Q_W-1:0] Q_HALF = Q_W'(SINE_DEPTH);
  localparam logic [Q_W-1:0] Q_FULL = Q_W'(2 * SINE_DEPTH);

  logic [SHADE_W-1:0] sine_rom   [0:SINE_DEPTH];
  logic [SHADE_W-1:0] factor_rom [0:(1 << CFG_W) - 1];

  for (genvar k = 0; k <= SINE_DEPTH; k++) begin : g_sine
    localparam longint XK = (HALF_PI_Q30 * longint'(k)) / SINE_DEPTH;
    assign sine_rom[k] = SHADE_W'(wts_quarter_sine(XK));
  end

  // Depths above the maximum behave as the maximum.
  for (genvar d = 0; d < (1 << CFG_W); d++) begin : g_factor
    localparam int DC = (d > 100) ? 100 : d;
    localparam int FV = 65536 - (DC * 393216 + 500) / 1000;
    assign factor_rom[d] = SHADE_W'(FV);
  end

  logic [Q_W-1:0]   q_clip;
  logic [IDX_W-1:0] idx;

  always_comb begin
    q_clip = (in_q > Q_FULL) ? Q_FULL : in_q;
    if (q_clip > Q_HALF) q_clip = Q_FULL - q_clip;
    idx = q_clip[IDX_W-1:0];
  end

  logic               a_v_r, b_v_r, c_v_r;
  logic               a_cross_r, b_cross_r;
  logic [SB_W-1:0]    a_sb_r, b_sb_r, c_sb_r;
  logic [SHADE_W-1:0] a_sine_r, b_shade_r, c_shade_r;

  logic [31:0]        swing_prod;
  logic [SHADE_W-1:0] b_shade_nxt;
  logic [33:0]        dark_prod;
  logic [SHADE_W-1:0] c_shade_nxt;

  always_comb begin
    swing_prod  = 32'(SHADE_SWING) * 32'(a_sine_r) + 32'd32768;
    b_shade_nxt = SHADE_BASE + SHADE_W'(swing_prod[31:16]);
    dark_prod   = 34'(b_shade_r) * 34'(factor_rom[depth_pct]) + 34'd32768;
    c_shade_nxt = b_cross_r ? SHADE_W'(dark_prod[33:16]) : b_shade_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
    end else begin
      a_v_r <= in_valid;
      b_v_r <= a_v_r;
      c_v_r <= b_v_r;
    end
    a_sine_r  <= sine_rom[idx];
    a_cross_r <= in_cross;
    a_sb_r    <= in_sb;
    b_shade_r <= b_shade_nxt;
    b_cross_r <= a_cross_r;
    b_sb_r    <= a_sb_r;
    c_shade_r <= c_shade_nxt;
    c_sb_r    <= b_sb_r;
  end

  assign out_valid = c_v_r;
  assign out_shade = c_shade_r;
  assign out_sb    = c_sb_r;

endmodule

FILE: rtl/core/woven_thread_pixel_shader_unit.sv
// Top level of the woven thread pixel shader: configuration registers,
// coordinate dividers, thread classification and channel scaling.
// Depends on wts_pkg, wts_div and wts_shade.
// Throughput: one pixel every cycle; busy stays low and results are never held.
// Reset (synchronous, rst_n low) empties the pipeline and restores the
// registers to width 8, gap 4 and depth 0.
`timescale 1ns / 1ps

module woven_thread_pixel_shader_unit
  import wts_pkg::*;
#(
  parameter int COORD_BITS       = DEF_COORD_BITS,
  parameter int SINE_TABLE_DEPTH = DEF_SINE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [COORD_BITS-1:0] in_pixel_x,
  input  logic [COORD_BITS-1:0] in_pixel_y,
  input  logic [7:0]            in_red,
  input  logic [7:0]            in_green,
  input  logic [7:0]            in_blue,
  input  logic [7:0]            in_alpha,
  output logic                  out_valid,
  output logic [7:0]            out_red,
  output logic [7:0]            out_green,
  output logic [7:0]            out_blue,
  output logic [7:0]            out_alpha,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CIDX_W-1:0]     cfg_index,
  input  logic [CFG_W-1:0]      cfg_data
);

  localparam int QN_W = $clog2(255 * SINE_TABLE_DEPTH + 64);
  localparam int PER_W = CFG_W + 1;
  localparam int QSB_W = 34;

  logic [CFG_W-1:0] width_r, gap_r, depth_r;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= RST_THREAD_WIDTH;
      gap_r   <= RST_GAP_WIDTH;
      depth_r <= RST_DEPTH_PERCENT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_THREAD_WIDTH:  width_r <= cfg_data;
        REG_GAP_WIDTH:     gap_r   <= cfg_data;
        REG_DEPTH_PERCENT: depth_r <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [CFG_W-1:0] th;
  logic [PER_W-1:0] period;
  logic [CFG_W-1:0] depth_eff;

  assign th        = (width_r < MIN_WIDTH) ? MIN_WIDTH : width_r;
  assign period    = {1'b0, th} + {1'b0, gap_r};
  assign depth_eff = (depth_r > MAX_DEPTH) ? MAX_DEPTH : depth_r;

  // Column and row are divided by the lattice period in parallel.
  logic                  xd_valid, yd_valid;
  logic [COORD_BITS-1:0] x_quo, y_quo;
  logic [PER_W-1:0]      x_rem, y_rem;
  logic [23:0]           x_sb;
  logic [7:0]            y_sb;

  wts_div #(.NUM_W(COORD_BITS), .DEN_W(PER_W), .SB_W(24)) u_div_x (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (start && !busy),
    .in_num    (in_pixel_x),
    .in_den    (period),
    .in_sb     ({in_red, in_green, in_blue}),
    .out_valid (xd_valid),
    .out_quo   (x_quo),
    .out_rem   (x_rem),
    .out_sb    (x_sb)
  );

  wts_div #(.NUM_W(COORD_BITS), .DEN_W(PER_W), .SB_W(8)) u_div_y (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (start && !busy),
    .in_num    (in_pixel_y),
    .in_den    (period),
    .in_sb     (in_alpha),
    .out_valid (yd_valid),
    .out_quo   (y_quo),
    .out_rem   (y_rem),
    .out_sb    (y_sb)
  );

  logic             in_h, in_v, v_top, show_v, on_gap, near_edge;
  logic [CFG_W-1:0] across, under, other, edge_dist;
  logic [QN_W-1:0]  num_nxt;

  always_comb begin
    in_h      = y_rem < {1'b0, th};
    in_v      = x_rem < {1'b0, th};
    on_gap    = !in_h && !in_v;
    v_top     = (x_quo[0] ^ y_quo[0]) == 1'b0;
    show_v    = in_v && (v_top || !in_h);
    across    = show_v ? x_rem[CFG_W-1:0] : y_rem[CFG_W-1:0];
    under     = show_v ? y_rem[CFG_W-1:0] : x_rem[CFG_W-1:0];
    other     = th - 7'd1 - under;
    edge_dist = (under < other) ? under : other;
    // Only crossings with darkening enabled are dimmed near the under-thread edge.
    near_edge = in_h && in_v && (depth_eff != '0) && (edge_dist <= 7'd1);
    num_nxt   = QN_W'({across, 1'b1}) * QN_W'(SINE_TABLE_DEPTH)
              + QN_W'(th[CFG_W-1:1]);
  end

  logic             p1_v_r;
  logic [QN_W-1:0]  p1_num_r;
  logic [QSB_W-1:0] p1_sb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
    end else begin
      p1_v_r <= xd_valid && yd_valid;
    end
    p1_num_r <= num_nxt;
    p1_sb_r  <= {near_edge, on_gap, x_sb, y_sb};
  end

  logic             qd_valid;
  logic [QN_W-1:0]  q_quo;
  logic [CFG_W-1:0] q_rem;
  logic [QSB_W-1:0] q_sb;

  wts_div #(.NUM_W(QN_W), .DEN_W(CFG_W), .SB_W(QSB_W)) u_div_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (p1_v_r),
    .in_num    (p1_num_r),
    .in_den    (th),
    .in_sb     (p1_sb_r),
    .out_valid (qd_valid),
    .out_quo   (q_quo),
    .out_rem   (q_rem),
    .out_sb    (q_sb)
  );

  logic               sh_valid;
  logic [SHADE_W-1:0] shade;
  logic [32:0]        sh_sb;

  wts_shade #(.SINE_DEPTH(SINE_TABLE_DEPTH), .Q_W(QN_W), .SB_W(33)) u_shade (
    .clk       (clk),
    .rst_n     (rst_n),
    .depth_pct (depth_eff),
    .in_valid  (qd_valid && (q_rem == q_rem)),
    .in_q      (q_quo),
    .in_cross  (q_sb[33]),
    .in_sb     (q_sb[32:0]),
    .out_valid (sh_valid),
    .out_shade (shade),
    .out_sb    (sh_sb)
  );

  logic       gap_f;
  logic [7:0] chan [0:2];
  logic [7:0] chan_nxt [0:2];
  logic [24:0] chan_prod [0:2];

  assign gap_f   = sh_sb[32];
  assign chan[0] = sh_sb[31:24];
  assign chan[1] = sh_sb[23:16];
  assign chan[2] = sh_sb[15:8];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      chan_prod[i] = 25'(chan[i]) * 25'(shade) + 25'd32768;
      if (gap_f) chan_nxt[i] = 8'd0;
      else if (chan_prod[i][24:16] > 9'd255) chan_nxt[i] = 8'd255;
      else chan_nxt[i] = chan_prod[i][23:16];
    end
  end

  logic       o_v_r;
  logic [7:0] o_red_r, o_green_r, o_blue_r, o_alpha_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_v_r <= 1'b0;
    end else begin
      o_v_r <= sh_valid;
    end
    o_red_r   <= chan_nxt[0];
    o_green_r <= chan_nxt[1];
    o_blue_r  <= chan_nxt[2];
    o_alpha_r <= gap_f ? 8'd0 : sh_sb[7:0];
  end

  assign out_valid = o_v_r;
  assign out_red   = o_red_r;
  assign out_green = o_green_r;
  assign out_blue  = o_blue_r;
  assign out_alpha = o_alpha_r;

endmodule
